// File: hdl/rpq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the reorderable positional queue.
// Used by rpq_cell and reorderable_positional_queue; depends on nothing.
package rpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ENTRY_WIDTH = 32;
  localparam int CMD_W       = 3;
  localparam int POS_W       = 4;
  localparam int CNT_W       = 5;
  localparam int DATA_W      = 32;

  // Command codes carried in the input transfer
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND    = 3'd0,
    CMD_POP       = 3'd1,
    CMD_REMOVE    = 3'd2,
    CMD_SWAP_NEXT = 3'd3,
    CMD_SWAP_PREV = 3'd4
  } cmd_t;

  // What the row of cells does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_REMOVE,
    CELL_SWAP
  } cell_op_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] entry_data;
  } in_item_t;

  typedef struct packed {
    logic              success;
    logic [DATA_W-1:0] popped_data;
    logic [CNT_W-1:0]  occupancy;
  } out_item_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t               op;
    logic [POS_W-1:0]       lo_idx;
    logic [CNT_W-1:0]       tail_idx;
    logic [ENTRY_WIDTH-1:0] load_entry;
  } cell_ctrl_t;

endpackage

// File: hdl/rpq_cell.sv
`timescale 1ns / 1ps
// One storage cell of the queue: holds a single entry and trades it with
// its neighbors as the broadcast control says. Depends on rpq_pkg.
module rpq_cell (
  input  logic                           clk,
  input  rpq_pkg::cell_ctrl_t            ctrl,
  input  logic [rpq_pkg::POS_W-1:0]      cell_idx,
  input  logic [rpq_pkg::ENTRY_WIDTH-1:0] prev_entry,
  input  logic [rpq_pkg::ENTRY_WIDTH-1:0] next_entry,
  output logic [rpq_pkg::ENTRY_WIDTH-1:0] entry
);
  import rpq_pkg::*;

  logic [ENTRY_WIDTH-1:0] entry_r;
  logic [ENTRY_WIDTH-1:0] entry_nxt;
  logic [CNT_W-1:0]       idx_ext;
  logic [CNT_W-1:0]       hi_idx;

  assign idx_ext = {1'b0, cell_idx};
  assign hi_idx  = {1'b0, ctrl.lo_idx} + CNT_W'(1);

  // Pick this cell's next entry: load, shift toward head, or swap
  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      CELL_APPEND: begin
        if (idx_ext == ctrl.tail_idx) entry_nxt = ctrl.load_entry;
      end
      CELL_REMOVE: begin
        if (cell_idx >= ctrl.lo_idx) entry_nxt = next_entry;
      end
      CELL_SWAP: begin
        if (cell_idx == ctrl.lo_idx) entry_nxt = next_entry;
        else if (idx_ext == hi_idx) entry_nxt = prev_entry;
      end
      default: entry_nxt = entry_r;
    endcase
  end

  // Payload register, no reset
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// File: hdl/reorderable_positional_queue.sv
`timescale 1ns / 1ps
// Reorderable positional queue: append, pop, remove at position and swaps.
// A command's result is registered into the output register in the cycle after its transfer.
// Throughput: one command per cycle while the output is not stalled; every cell shifts or swaps in parallel.
// Reset clears the occupancy and the output valid; stored entries are not cleared.
// Depends on rpq_pkg and rpq_cell.
module reorderable_positional_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rpq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rpq_pkg::out_item_t out_data
);
  import rpq_pkg::*;

  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  out_item_t              out_data_r;
  out_item_t              out_data_nxt;
  logic                   in_fire;
  logic                   ok;
  logic [DATA_W-1:0]      popped;
  cell_ctrl_t             ctrl;
  logic [CNT_W-1:0]       pos_ext;
  logic [ENTRY_WIDTH-1:0] cell_entry [QUEUE_DEPTH];

  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;
  assign pos_ext  = {1'b0, in_data.position};

  // Decode the command into a row-wide cell operation
  always_comb begin
    ok              = 1'b0;
    popped          = '0;
    count_nxt       = count_r;
    ctrl.op         = CELL_HOLD;
    ctrl.lo_idx     = in_data.position;
    ctrl.tail_idx   = count_r;
    ctrl.load_entry = in_data.entry_data[ENTRY_WIDTH-1:0];
    case (in_data.command)
      CMD_APPEND: begin
        ok        = count_r < CNT_W'(QUEUE_DEPTH);
        ctrl.op   = CELL_APPEND;
        count_nxt = count_r + CNT_W'(1);
      end
      CMD_POP: begin
        ok          = count_r != '0;
        ctrl.op     = CELL_REMOVE;
        ctrl.lo_idx = '0;
        popped      = DATA_W'(cell_entry[0]);
        count_nxt   = count_r - CNT_W'(1);
      end
      CMD_REMOVE: begin
        ok        = pos_ext < count_r;
        ctrl.op   = CELL_REMOVE;
        count_nxt = count_r - CNT_W'(1);
      end
      CMD_SWAP_NEXT: begin
        ok      = (pos_ext + CNT_W'(1)) < count_r;
        ctrl.op = CELL_SWAP;
      end
      CMD_SWAP_PREV: begin
        ok          = (in_data.position != '0) && (pos_ext < count_r);
        ctrl.op     = CELL_SWAP;
        ctrl.lo_idx = in_data.position - POS_W'(1);
      end
      default: ok = 1'b0;
    endcase
    // Drop the command when it fails or no transfer happens
    if (!ok || !in_fire) begin
      ctrl.op   = CELL_HOLD;
      count_nxt = count_r;
      popped    = '0;
    end
  end

  // Row of cells, each wired to its neighbors; the ends loop back on themselves
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] prev_e;
    logic [ENTRY_WIDTH-1:0] next_e;
    if (g == 0) begin : g_head
      assign prev_e = cell_entry[g];
    end else begin : g_mid_p
      assign prev_e = cell_entry[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign next_e = cell_entry[g];
    end else begin : g_mid_n
      assign next_e = cell_entry[g+1];
    end
    rpq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cell_idx   (POS_W'(g)),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .entry      (cell_entry[g])
    );
  end

  // Output register: load on transfer in, clear when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_fire) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.success     = ok;
      out_data_nxt.popped_data = popped;
      out_data_nxt.occupancy   = count_nxt;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy above depth");

  a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.occupancy == count_r)
    else $error("reported occupancy differs from count");

  a_fail_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !ok) |=> $stable(count_r))
    else $error("failed command changed occupancy");

  a_append_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && ok && in_data.command == CMD_APPEND)
      |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("append did not grow occupancy");
`endif

endmodule
